>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Clocked, reset-qualified concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define RYUV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define RYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ryuv_pkg.sv
// Package for the RGB to YCbCr 4:2:0 converter: sizes, coefficients, types.
// No dependencies; used by every other file of the block but assert_macros.svh.
package ryuv_pkg;

  // Frame geometry
  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int LINE_AW      = $clog2(LINE_DEPTH);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W        = 13;
  localparam int CLAMP_W      = DIM_W + 1;

  localparam logic [CLAMP_W-1:0] WIDTH_MAX  = CLAMP_W'(MAX_WIDTH);
  localparam logic [CLAMP_W-1:0] HEIGHT_MAX = CLAMP_W'(HEIGHT_LIMIT);
  localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(480);

  // Pixel and chroma widths
  localparam int PIX_W  = 8;
  localparam int PAIR_W = PIX_W + 1;
  localparam int ACC_W  = 24;

  // BT.601 coefficients in Q0.16, rounded
  localparam logic [15:0] Y_R  = 16'd16843;
  localparam logic [15:0] Y_G  = 16'd33030;
  localparam logic [15:0] Y_B  = 16'd6423;
  localparam logic [15:0] CB_R = 16'd9699;
  localparam logic [15:0] CB_G = 16'd19071;
  localparam logic [15:0] CB_B = 16'd28770;
  localparam logic [15:0] CR_R = 16'd28770;
  localparam logic [15:0] CR_G = 16'd24117;
  localparam logic [15:0] CR_B = 16'd4653;

  localparam logic [PIX_W-1:0] LUMA_OFFSET = 8'd16;
  localparam logic [ACC_W-1:0] CHROMA_BIAS = 24'd8388608;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [DIM_W-1:0] dim_t;

  // Position of one pixel within the frame
  typedef struct packed {
    logic               col_odd;
    logic               row_odd;
    logic [LINE_AW-1:0] idx;
    logic               frame_end;
  } pos_t;

  // Clear the low bit and clamp into [2, hi]
  function automatic logic [CLAMP_W-1:0] even_clamp(input dim_t v,
                                                    input logic [CLAMP_W-1:0] hi);
    logic [CLAMP_W-1:0] e;
    e = {1'b0, v[DIM_W-1:1], 1'b0};
    if (e < CLAMP_W'(2)) e = CLAMP_W'(2);
    if (e > hi) e = hi;
    return e;
  endfunction

endpackage

>>> hw/rtl/ryuv_pix_if.sv
// Input pixel channel: valid/ready handshake with a BGR payload.
// Depends on ryuv_pkg for the component width.
interface ryuv_pix_if;
  logic                       valid;
  logic                       ready;
  logic [ryuv_pkg::PIX_W-1:0] blue;
  logic [ryuv_pkg::PIX_W-1:0] green;
  logic [ryuv_pkg::PIX_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

>>> hw/rtl/ryuv_res_if.sv
// Result channel: valid/ready handshake with luma, 4:2:0 chroma and frame marker.
// Depends on ryuv_pkg for the component width.
interface ryuv_res_if;
  logic                       valid;
  logic                       ready;
  logic [ryuv_pkg::PIX_W-1:0] luma;
  logic                       chroma_valid;
  logic [ryuv_pkg::PIX_W-1:0] cb_avg;
  logic [ryuv_pkg::PIX_W-1:0] cr_avg;
  logic                       frame_end;

  modport source (output valid, luma, chroma_valid, cb_avg, cr_avg, frame_end,
                  input ready);
  modport sink   (input valid, luma, chroma_valid, cb_avg, cr_avg, frame_end,
                  output ready);
endinterface

>>> hw/rtl/ryuv_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on ryuv_pkg for the data width.
interface ryuv_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [0:0]                 index;
  logic [ryuv_pkg::DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ryuv_ctrl.sv
// Frame geometry registers and column/row counters for the converter.
// Depends on ryuv_pkg.
module ryuv_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  ryuv_pkg::dim_t             cfg_data,
  input  logic                       adv,
  output ryuv_pkg::pos_t             pos
);

  ryuv_pkg::dim_t                      width_r, width_nxt;
  ryuv_pkg::dim_t                      height_r, height_nxt;
  logic [ryuv_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [ryuv_pkg::ROW_W-1:0]          row_r, row_nxt;
  logic [ryuv_pkg::CLAMP_W-1:0]        col_last;
  logic [ryuv_pkg::CLAMP_W-1:0]        row_last;
  logic                                col_wrap;
  logic                                row_wrap;

  // Register decode
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (ryuv_pkg::cfg_idx_t'(cfg_index))
        ryuv_pkg::CFG_FRAME_WIDTH:  width_nxt  = cfg_data;
        ryuv_pkg::CFG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Last valid column and row under the current geometry
  assign col_last = ryuv_pkg::even_clamp(width_r, ryuv_pkg::WIDTH_MAX)
                    - ryuv_pkg::CLAMP_W'(1);
  assign row_last = ryuv_pkg::even_clamp(height_r, ryuv_pkg::HEIGHT_MAX)
                    - ryuv_pkg::CLAMP_W'(1);
  assign col_wrap = (ryuv_pkg::CLAMP_W'(col_r) >= col_last);
  assign row_wrap = (ryuv_pkg::CLAMP_W'(row_r) >= row_last);

  // Counter advance per accepted pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + ryuv_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + ryuv_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ryuv_pkg::WIDTH_RST;
      height_r <= ryuv_pkg::HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Position of the pixel being accepted now
  assign pos.col_odd   = col_r[0];
  assign pos.row_odd   = row_r[0];
  assign pos.idx       = col_r[ryuv_pkg::COL_W-1:1];
  assign pos.frame_end = col_wrap & row_wrap;

endmodule

>>> hw/rtl/ryuv_csc.sv
// BT.601 studio-range color conversion of one pixel, constant multiplies only.
// Depends on ryuv_pkg.
module ryuv_csc (
  input  logic [ryuv_pkg::PIX_W-1:0] blue,
  input  logic [ryuv_pkg::PIX_W-1:0] green,
  input  logic [ryuv_pkg::PIX_W-1:0] red,
  output logic [ryuv_pkg::PIX_W-1:0] luma,
  output logic [ryuv_pkg::PIX_W-1:0] cb,
  output logic [ryuv_pkg::PIX_W-1:0] cr
);

  localparam int AW = ryuv_pkg::ACC_W;

  logic [AW-1:0] r_x, g_x, b_x;
  logic [AW-1:0] y_sum, cb_sum, cr_sum;

  assign r_x = AW'(red);
  assign g_x = AW'(green);
  assign b_x = AW'(blue);

  // Q8.16 sums; all stay within 24 bits and never go negative
  assign y_sum  = AW'(ryuv_pkg::Y_R) * r_x + AW'(ryuv_pkg::Y_G) * g_x
                + AW'(ryuv_pkg::Y_B) * b_x;
  assign cb_sum = AW'(ryuv_pkg::CB_B) * b_x + ryuv_pkg::CHROMA_BIAS
                - AW'(ryuv_pkg::CB_R) * r_x - AW'(ryuv_pkg::CB_G) * g_x;
  assign cr_sum = AW'(ryuv_pkg::CR_R) * r_x + ryuv_pkg::CHROMA_BIAS
                - AW'(ryuv_pkg::CR_G) * g_x - AW'(ryuv_pkg::CR_B) * b_x;

  // Floor by taking the integer byte
  assign luma = ryuv_pkg::LUMA_OFFSET + y_sum[AW-1:16];
  assign cb   = cb_sum[AW-1:16];
  assign cr   = cr_sum[AW-1:16];

endmodule

>>> hw/rtl/ryuv_line_buf.sv
// Line store of even-row horizontal chroma pair sums (Cb and Cr side by side).
// One write and one registered read per cycle; depends on ryuv_pkg.
module ryuv_line_buf (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ryuv_pkg::LINE_AW-1:0]  rd_addr,
  output logic [2*ryuv_pkg::PAIR_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [ryuv_pkg::LINE_AW-1:0]  wr_addr,
  input  logic [2*ryuv_pkg::PAIR_W-1:0] wr_data
);

  logic [2*ryuv_pkg::PAIR_W-1:0] mem [ryuv_pkg::LINE_DEPTH];
  logic [2*ryuv_pkg::PAIR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/rgb_to_yuv420_converter.sv
// RGB to YCbCr 4:2:0 converter, BT.601 studio range, one pixel per clock.
// Channels: in_px takes BGR pixels in raster order, out_px returns one result
// per pixel (luma, plus the 2x2 block chroma average on the block's
// bottom-right pixel), cfg_wr writes frame width (index 0) and height (1).
// Both dimensions are rounded down to even and clamped to 2..4096.
// A pixel accepted on in_px passes two register stages, the input register
// and the result register, before it is presented on out_px. Throughput:
// one pixel per cycle while out_px does not stall, set by the single line
// store read port and the constant-multiply conversion between the two registers.
// The line store holds the even rows' pair sums; it needs no clearing, so the
// block accepts pixels from the first cycle after reset. Reset returns the
// counters to the frame start and the geometry to 640 x 480. When out_px
// stalls, the result register holds and the input register keeps one more pixel;
// in_px.ready then drops until the receiver takes a result. Configuration writes
// are always ready; the user must make them with no pixel in flight, unchecked.
`include "assert_macros.svh"

module rgb_to_yuv420_converter (
  input  logic        clk,
  input  logic        rst_n,
  ryuv_pix_if.sink    in_px,
  ryuv_res_if.source  out_px,
  ryuv_cfg_if.sink    cfg_wr
);

  localparam int PW = ryuv_pkg::PIX_W;
  localparam int QW = ryuv_pkg::PAIR_W;

  logic                   in_acc;
  logic                   s1_go;
  ryuv_pkg::pos_t         pos;

  // Input register stage
  logic                   s1_v_r;
  logic [PW-1:0]          s1_blue_r, s1_green_r, s1_red_r;
  ryuv_pkg::pos_t         s1_pos_r;

  // Conversion and chroma
  logic [PW-1:0]          px_luma, px_cb, px_cr;
  logic [PW-1:0]          held_cb_r, held_cr_r;
  logic [QW-1:0]          pair_cb, pair_cr;
  logic [2*QW-1:0]        line_rd;
  logic [QW:0]            tot_cb, tot_cr;
  logic                   line_we;
  logic                   s1_chroma;

  // Result register stage
  logic                   out_v_r;
  logic [PW-1:0]          out_luma_r, out_cb_r, out_cr_r;
  logic                   out_chroma_r, out_fend_r;

  // Handshakes
  assign s1_go        = !out_v_r || out_px.ready;
  assign in_px.ready  = !s1_v_r || s1_go;
  assign in_acc       = in_px.valid && in_px.ready;
  assign cfg_wr.ready = 1'b1;

  ryuv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .adv       (in_acc),
    .pos       (pos)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_px.ready) begin
      s1_v_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_blue_r  <= in_px.blue;
      s1_green_r <= in_px.green;
      s1_red_r   <= in_px.red;
      s1_pos_r   <= pos;
    end
  end

  ryuv_csc u_csc (
    .blue  (s1_blue_r),
    .green (s1_green_r),
    .red   (s1_red_r),
    .luma  (px_luma),
    .cb    (px_cb),
    .cr    (px_cr)
  );

  // Even column: hold its chroma for the pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cb_r <= '0;
      held_cr_r <= '0;
    end else if (s1_v_r && s1_go && !s1_pos_r.col_odd) begin
      held_cb_r <= px_cb;
      held_cr_r <= px_cr;
    end
  end

  assign pair_cb = QW'(held_cb_r) + QW'(px_cb);
  assign pair_cr = QW'(held_cr_r) + QW'(px_cr);

  // Even row, odd column: store the pair sum; read for a pixel issued at accept
  assign line_we = s1_v_r && s1_go && s1_pos_r.col_odd && !s1_pos_r.row_odd;

  ryuv_line_buf u_line (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos.idx),
    .rd_data (line_rd),
    .wr_en   (line_we),
    .wr_addr (s1_pos_r.idx),
    .wr_data ({pair_cb, pair_cr})
  );

  // Odd row, odd column: finish the 2x2 block
  assign s1_chroma = s1_pos_r.col_odd && s1_pos_r.row_odd;
  assign tot_cb    = (QW+1)'(pair_cb) + (QW+1)'(line_rd[2*QW-1:QW]);
  assign tot_cr    = (QW+1)'(pair_cr) + (QW+1)'(line_rd[QW-1:0]);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_go) begin
      out_luma_r   <= px_luma;
      out_chroma_r <= s1_chroma;
      out_cb_r     <= s1_chroma ? tot_cb[QW:2] : '0;
      out_cr_r     <= s1_chroma ? tot_cr[QW:2] : '0;
      out_fend_r   <= s1_pos_r.frame_end;
    end
  end

  assign out_px.valid        = out_v_r;
  assign out_px.luma         = out_luma_r;
  assign out_px.chroma_valid = out_chroma_r;
  assign out_px.cb_avg       = out_cb_r;
  assign out_px.cr_avg       = out_cr_r;
  assign out_px.frame_end    = out_fend_r;

  // Checks
  `RYUV_ASSERT(a_ready_when_empty, clk, rst_n, !out_v_r |-> in_px.ready, "input stalled with empty result register")
  `RYUV_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_acc, s1_v_r, "accepted pixel not held in input register")
  `RYUV_ASSERT(a_chroma_zero, clk, rst_n, (out_v_r && !out_chroma_r) |-> (out_cb_r == '0 && out_cr_r == '0), "chroma nonzero without a finished block")

endmodule
